### rtl/tss_pkg.sv
// Package for the task scheduler: sizes, command codes, state encoding.
// No dependencies.
package tss_pkg;
    localparam int NUM_TASKS = 8;
    localparam int NUM_SEMS  = 8;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int SW = $clog2(NUM_SEMS);
    localparam int MS_PER_SECOND = 1000;
    localparam logic [9:0] TICK_RATE_RESET = 10'd100;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_SCHED = 3'd1,
        MODE_SLEEP = 3'd2,
        MODE_SEM_P = 3'd3,
        MODE_SEM_V = 3'd4,
        MODE_PRIO  = 3'd5,
        MODE_SEM_SET = 3'd6,
        MODE_NOP   = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEMRD,
        ST_CMD,
        ST_MULT,
        ST_UNBLK,
        ST_PICK,
        ST_RELOAD,
        ST_PICK2,
        ST_DONE
    } state_t;

    // one task record as held in the task memory
    typedef struct packed {
        logic [7:0]    quantum;
        logic [7:0]    prio;
        logic [15:0]   sleep;
        logic          blocked;
        logic [SW-1:0] bsem;
    } task_rec_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  task_index;
        logic [2:0]  sem_index;
        logic [15:0] sleep_ms;
        logic [7:0]  new_priority;
        logic [15:0] sem_init;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  ready_task;
        logic        none_ready;
        logic        caller_blocked;
        logic [15:0] sem_level;
        logic [31:0] elapsed_ticks;
    } res_t;
endpackage

### rtl/tss_if.sv
// Valid/ready channels, one for commands and one for results.
// Depends on tss_pkg through the fixed command and result payload types.
interface tss_cmd_if;
    logic         valid;
    logic         ready;
    tss_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tss_res_if;
    logic         valid;
    logic         ready;
    tss_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/tss_task_mem.sv
// Task table memory: one record per task, one write and one read port,
// registered read data. Depends on tss_pkg.
module tss_task_mem (
    input  logic                    clk,
    input  logic                    we,
    input  logic [tss_pkg::TW-1:0]  waddr,
    input  tss_pkg::task_rec_t      wdata,
    input  logic [tss_pkg::TW-1:0]  raddr,
    output tss_pkg::task_rec_t      rdata
);
    tss_pkg::task_rec_t mem [tss_pkg::NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/tss_sem_mem.sv
// Semaphore count memory, one write and one read port, registered read.
// Depends on tss_pkg.
module tss_sem_mem (
    input  logic                    clk,
    input  logic                    we,
    input  logic [tss_pkg::SW-1:0]  waddr,
    input  logic [15:0]             wdata,
    input  logic [tss_pkg::SW-1:0]  raddr,
    output logic [15:0]             rdata
);
    logic [15:0] mem [tss_pkg::NUM_SEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/task_scheduler_with_semaphores.sv
// Task scheduler with counting semaphores, memory-centered sequencer.
// Commands that do not schedule pass through SEMRD and CMD to DONE; scheduling adds
// up to four sweeps of the task table: UNBLK, PICK, then RELOAD and PICK2 if none is ready.
// Flow: one command at a time; the next transfer waits until the result
// registers. A stalled result holds the sequencer.
// Reset: rst_n async active low, then a clearing pass over max(NUM_TASKS,NUM_SEMS) entries.
module task_scheduler_with_semaphores (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [9:0]        cfg_wdata,
    tss_cmd_if.sink           cmd,
    tss_res_if.source         res
);
    localparam int TW = tss_pkg::TW;
    localparam int SW = tss_pkg::SW;
    localparam int CW = (TW > SW) ? TW + 1 : SW + 1;

    tss_pkg::state_t state_reg, state_next;
    tss_pkg::cmd_t   cmd_reg;
    logic [9:0]      rate_reg;
    logic [TW-1:0]   run_reg;
    logic [31:0]     ticks_reg;
    logic            none_reg;
    logic            blk_reg;
    logic [CW-1:0]   clr_reg;
    logic            clr_done_reg;
    // scan bookkeeping
    logic [TW:0]     idx_reg;      // index of the record arriving from memory
    logic            rd_v_reg;     // a read was issued last cycle
    logic [7:0]      best_reg;
    logic [TW-1:0]   best_idx_reg;
    logic            found_reg;
    logic [15:0]     semv_reg;
    logic [25:0]     prod_reg;
    logic            res_v_reg;
    tss_pkg::res_t   res_reg;
    // unblock sweep write-back stage: record is held in a register while its sem read completes
    logic            wb_v_reg;
    logic [TW-1:0]   wb_idx_reg;
    tss_pkg::task_rec_t wb_rec_reg;
    tss_pkg::task_rec_t unblk_rec;
    // PRIO is read-modify-write: the write lands in the first DONE cycle
    logic            prio_wr_reg;

    // memory ports
    logic               t_we, s_we;
    logic [TW-1:0]      t_waddr, t_raddr;
    tss_pkg::task_rec_t t_wdata, t_rdata;
    logic [SW-1:0]      s_waddr, s_raddr;
    logic [15:0]        s_wdata, s_rdata;

    tss_task_mem u_tmem (.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
                         .raddr(t_raddr), .rdata(t_rdata));
    tss_sem_mem  u_smem (.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
                         .raddr(s_raddr), .rdata(s_rdata));

    logic sem_ok, tsk_ok;
    logic [TW:0] last_idx;
    logic        scan_end;
    logic [16:0] ticks_div;
    logic [15:0] sleep_sat;

    assign sem_ok   = {1'b0, cmd_reg.sem_index} < 4'(tss_pkg::NUM_SEMS);
    assign tsk_ok   = {1'b0, cmd_reg.task_index} < 4'(tss_pkg::NUM_TASKS);
    assign last_idx = (TW+1)'(tss_pkg::NUM_TASKS - 1);
    assign scan_end = rd_v_reg && (idx_reg == last_idx);
    // divide by 1000 via reciprocal: floor(x*ceil(2^40/1000)/2^40) exact for x<2^26
    assign ticks_div = 17'((58'(prod_reg) * 58'd1099511628) >> 40);
    assign sleep_sat = (ticks_div > 17'hFFFF) ? 16'hFFFF : ticks_div[15:0];

    // record in the write-back stage: sem of its blocking index is now visible
    logic unblk_hit;
    assign unblk_hit = wb_rec_reg.blocked && (s_rdata != 16'd0);

    logic elig;
    assign elig = !t_rdata.blocked && (t_rdata.sleep == 16'd0)
                  && (t_rdata.quantum > best_reg);

    // tick accounting applied to the record arriving in the unblock sweep
    always_comb
    begin
        unblk_rec = t_rdata;
        if (tss_pkg::mode_t'(cmd_reg.mode) == tss_pkg::MODE_TICK)
        begin
            if (t_rdata.sleep != 16'd0)
                unblk_rec.sleep = t_rdata.sleep - 16'd1;
            if (idx_reg[TW-1:0] == run_reg && t_rdata.quantum != 8'd0)
                unblk_rec.quantum = t_rdata.quantum - 8'd1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tss_pkg::ST_IDLE:
                if (cmd.valid && cmd.ready) state_next = tss_pkg::ST_SEMRD;
            tss_pkg::ST_SEMRD:  state_next = tss_pkg::ST_CMD;
            tss_pkg::ST_CMD:
                case (tss_pkg::mode_t'(cmd_reg.mode))
                    tss_pkg::MODE_TICK, tss_pkg::MODE_SCHED:
                        state_next = tss_pkg::ST_UNBLK;
                    tss_pkg::MODE_SLEEP: state_next = tss_pkg::ST_MULT;
                    tss_pkg::MODE_SEM_P:
                        state_next = (sem_ok && s_rdata == 16'd0) ?
                                     tss_pkg::ST_UNBLK : tss_pkg::ST_DONE;
                    default: state_next = tss_pkg::ST_DONE;
                endcase
            tss_pkg::ST_MULT:   state_next = tss_pkg::ST_UNBLK;
            tss_pkg::ST_UNBLK:  if (scan_end) state_next = tss_pkg::ST_PICK;
            tss_pkg::ST_PICK:
                if (scan_end)
                    state_next = (found_reg || elig) ? tss_pkg::ST_DONE
                                                     : tss_pkg::ST_RELOAD;
            tss_pkg::ST_RELOAD: if (scan_end) state_next = tss_pkg::ST_PICK2;
            tss_pkg::ST_PICK2:  if (scan_end) state_next = tss_pkg::ST_DONE;
            tss_pkg::ST_DONE:
                if (!res_v_reg || res.ready) state_next = tss_pkg::ST_IDLE;
            default: state_next = tss_pkg::ST_IDLE;
        endcase
    end

    // memory addressing and write-back
    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = idx_reg[TW-1:0];
        t_wdata = t_rdata;
        t_raddr = run_reg;
        s_we    = 1'b0;
        s_waddr = cmd_reg.sem_index[SW-1:0];
        s_wdata = s_rdata;
        s_raddr = cmd_reg.sem_index[SW-1:0];
        if (!clr_done_reg)
        begin
            t_we = {1'b0, clr_reg} < (CW+1)'(tss_pkg::NUM_TASKS);
            s_we = {1'b0, clr_reg} < (CW+1)'(tss_pkg::NUM_SEMS);
            t_waddr = clr_reg[TW-1:0];
            s_waddr = clr_reg[SW-1:0];
            t_wdata = '0;
            s_wdata = '0;
        end
        else
        begin
            case (state_reg)
                tss_pkg::ST_IDLE:
                    s_raddr = cmd.data.sem_index[SW-1:0];
                tss_pkg::ST_CMD:
                begin
                    t_waddr = run_reg;
                    case (tss_pkg::mode_t'(cmd_reg.mode))
                        tss_pkg::MODE_SEM_P:
                            if (sem_ok)
                            begin
                                if (s_rdata == 16'd0)
                                begin
                                    t_we = 1'b1;
                                    t_wdata.blocked = 1'b1;
                                    t_wdata.bsem = cmd_reg.sem_index[SW-1:0];
                                end
                                else
                                begin
                                    s_we = 1'b1;
                                    s_wdata = s_rdata - 16'd1;
                                end
                            end
                        tss_pkg::MODE_SEM_V:
                            if (sem_ok && s_rdata != 16'hFFFF)
                            begin
                                s_we = 1'b1;
                                s_wdata = s_rdata + 16'd1;
                            end
                        tss_pkg::MODE_SEM_SET:
                            if (sem_ok)
                            begin
                                s_we = 1'b1;
                                s_wdata = cmd_reg.sem_init;
                            end
                        tss_pkg::MODE_PRIO:
                            if (tsk_ok)
                            begin
                                t_raddr = cmd_reg.task_index[TW-1:0];
                            end
                        default: ;
                    endcase
                end
                tss_pkg::ST_MULT:
                begin
                    t_we = 1'b1;
                    t_waddr = run_reg;
                    t_wdata.sleep = sleep_sat;
                    t_raddr = '0;
                end
                tss_pkg::ST_UNBLK:
                begin
                    // issue read of next record, sem read of the visible one
                    t_raddr = idx_reg[TW-1:0] + TW'(rd_v_reg);
                    if (rd_v_reg) s_raddr = t_rdata.bsem;
                    if (scan_end) t_raddr = '0;
                end
                tss_pkg::ST_PICK, tss_pkg::ST_PICK2, tss_pkg::ST_RELOAD:
                begin
                    t_raddr = idx_reg[TW-1:0] + TW'(rd_v_reg);
                    if (state_reg == tss_pkg::ST_RELOAD && rd_v_reg)
                    begin
                        t_we = 1'b1;
                        t_wdata.quantum = t_rdata.prio;
                    end
                    if (scan_end) t_raddr = '0;
                end
                tss_pkg::ST_DONE:
                    if (prio_wr_reg)
                    begin
                        t_we = 1'b1;
                        t_waddr = cmd_reg.task_index[TW-1:0];
                        t_wdata.prio = cmd_reg.new_priority;
                    end
                default: ;
            endcase
            // unblock sweep write-back, in the cycle after the record arrives
            if (wb_v_reg)
            begin
                t_we = 1'b1;
                t_waddr = wb_idx_reg;
                t_wdata = wb_rec_reg;
                if (unblk_hit) t_wdata.blocked = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tss_pkg::ST_IDLE;
            rate_reg     <= tss_pkg::TICK_RATE_RESET;
            run_reg      <= '0;
            ticks_reg    <= '0;
            none_reg     <= 1'b0;
            blk_reg      <= 1'b0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            idx_reg      <= '0;
            rd_v_reg     <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            res_v_reg    <= 1'b0;
            prio_wr_reg  <= 1'b0;
            wb_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we) rate_reg <= cfg_wdata;
            if (!clr_done_reg)
            begin
                clr_reg <= clr_reg + CW'(1);
                if ({1'b0, clr_reg} == (CW+1)'((tss_pkg::NUM_TASKS > tss_pkg::NUM_SEMS) ?
                    tss_pkg::NUM_TASKS - 1 : tss_pkg::NUM_SEMS - 1))
                    clr_done_reg <= 1'b1;
            end
            state_reg <= state_next;
            prio_wr_reg <= 1'b0;
            wb_v_reg <= (state_reg == tss_pkg::ST_UNBLK) && rd_v_reg;
            case (state_reg)
                tss_pkg::ST_IDLE:
                begin
                    blk_reg <= 1'b0;
                    idx_reg <= '0;
                    rd_v_reg <= 1'b0;
                end
                tss_pkg::ST_CMD:
                begin
                    if (tss_pkg::mode_t'(cmd_reg.mode) == tss_pkg::MODE_TICK)
                        ticks_reg <= ticks_reg + 32'd1;
                    if (tss_pkg::mode_t'(cmd_reg.mode) == tss_pkg::MODE_SEM_P
                        && sem_ok && s_rdata == 16'd0)
                        blk_reg <= 1'b1;
                    if (tss_pkg::mode_t'(cmd_reg.mode) == tss_pkg::MODE_PRIO && tsk_ok)
                        prio_wr_reg <= 1'b1;
                    rd_v_reg <= 1'b0;
                    idx_reg <= '0;
                end
                tss_pkg::ST_UNBLK, tss_pkg::ST_PICK, tss_pkg::ST_RELOAD,
                tss_pkg::ST_PICK2:
                begin
                    if (rd_v_reg) idx_reg <= idx_reg + (TW+1)'(1);
                    rd_v_reg <= 1'b1;
                    if ((state_reg == tss_pkg::ST_PICK || state_reg == tss_pkg::ST_PICK2)
                        && rd_v_reg && elig)
                    begin
                        best_reg <= t_rdata.quantum;
                        best_idx_reg <= idx_reg[TW-1:0];
                        found_reg <= 1'b1;
                    end
                    if (scan_end)
                    begin
                        idx_reg <= '0;
                        rd_v_reg <= 1'b0;
                        best_reg <= '0;
                        if (state_reg == tss_pkg::ST_UNBLK ||
                            state_reg == tss_pkg::ST_RELOAD)
                            found_reg <= 1'b0;
                        if (state_reg == tss_pkg::ST_PICK ||
                            state_reg == tss_pkg::ST_PICK2)
                        begin
                            if (found_reg || elig)
                            begin
                                run_reg <= elig ? idx_reg[TW-1:0] : best_idx_reg;
                                none_reg <= 1'b0;
                            end
                            else if (state_reg == tss_pkg::ST_PICK2)
                                none_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (state_reg == tss_pkg::ST_UNBLK && !rd_v_reg) found_reg <= 1'b0;
            // result slot: load in DONE, free on transfer
            if (state_reg == tss_pkg::ST_DONE && (!res_v_reg || res.ready))
                res_v_reg <= 1'b1;
            else if (res.ready)
                res_v_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) cmd_reg <= cmd.data;
        prod_reg <= 26'(cmd_reg.sleep_ms) * 26'(rate_reg);
        if (state_reg == tss_pkg::ST_DONE && (!res_v_reg || res.ready))
        begin
            res_reg.ready_task     <= 3'(run_reg);
            res_reg.none_ready     <= none_reg;
            res_reg.caller_blocked <= blk_reg;
            res_reg.sem_level      <= sem_ok ? semv_reg : 16'd0;
            res_reg.elapsed_ticks  <= ticks_reg;
        end
        // track semaphore value after the command's own update
        if (state_reg == tss_pkg::ST_CMD) semv_reg <= s_we ? s_wdata : s_rdata;
        // hold the swept record while its semaphore is read
        if (state_reg == tss_pkg::ST_UNBLK && rd_v_reg)
        begin
            wb_rec_reg <= unblk_rec;
            wb_idx_reg <= idx_reg[TW-1:0];
        end
    end

    assign cmd.ready = clr_done_reg && state_reg == tss_pkg::ST_IDLE;
    assign res.valid = res_v_reg;
    assign res.data  = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.data))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("second command taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |-> !cmd.ready)
        else $error("command accepted during clear pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tss_pkg::ST_PICK2 && scan_end |=> state_reg == tss_pkg::ST_DONE)
        else $error("second pick did not finish");
endmodule
